### hw/rtl/dls_pkg.sv
// shared types, constants and the sigmoid table for the dense sigmoid layer
`timescale 1ns / 1ps

package dls_pkg;

    // store sizes
    localparam int IN_MAX  = 16;
    localparam int OUT_MAX = 16;
    localparam int IN_LIM  = (IN_MAX < 16) ? IN_MAX : 16;
    localparam int OUT_LIM = (OUT_MAX < 16) ? OUT_MAX : 16;
    localparam int IN_AW   = $clog2(IN_MAX);
    localparam int OUT_AW  = $clog2(OUT_MAX);
    localparam int WA_W    = $clog2(IN_MAX * OUT_MAX);

    // field widths
    localparam int IDX_W  = 4;
    localparam int VAL_W  = 16;
    localparam int ACT_W  = 13;
    localparam int SIZE_W = 5;
    localparam int PROD_W = 2 * VAL_W;
    localparam int ACC_W  = PROD_W + $clog2(IN_MAX + 1) + 1;

    // saturation span of the table: [-8, 8) in Q.24
    localparam int SPAN_BIT = 27;
    localparam int FRAC_SH  = 12;

    // queue depths
    localparam int CQ_DEPTH = 4;
    localparam int CQ_AW    = $clog2(CQ_DEPTH);
    localparam int OQ_DEPTH = 2;
    localparam int OQ_AW    = $clog2(OQ_DEPTH);
    localparam int OQ_CW    = $clog2(OQ_DEPTH + 1);

    // configuration port
    localparam int CFG_AW = 1;
    localparam logic [CFG_AW-1:0] REG_IN_SIZE  = 1'b0;
    localparam logic [CFG_AW-1:0] REG_OUT_SIZE = 1'b1;
    localparam logic [SIZE_W-1:0] SIZE_RESET   = 5'd16;

    typedef enum logic [1:0] {
        MODE_WEIGHT = 2'd0,
        MODE_BIAS   = 2'd1,
        MODE_INPUT  = 2'd2,
        MODE_RUN    = 2'd3
    } mode_t;

    typedef enum logic {
        BK_IDLE = 1'b0,
        BK_RUN  = 1'b1
    } bk_state_t;

    // one classified command from the front queue
    typedef struct packed {
        mode_t                   kind;
        logic [IDX_W-1:0]        row;
        logic [IDX_W-1:0]        col;
        logic signed [VAL_W-1:0] value;
    } cmd_t;

    // one activation result
    typedef struct packed {
        logic             last;
        logic [ACT_W-1:0] activation;
        logic [IDX_W-1:0] out_index;
    } res_t;

    typedef logic [ACT_W-1:0] sig_table_t [256];

    // e^(-1/32) in Q.32
    localparam logic [63:0] EXP_STEP = 64'd4162825044;

    // restoring long division, used only while building the table
    function automatic logic [63:0] udiv64(logic [63:0] num, logic [63:0] den);
        logic [63:0] quo;
        logic [64:0] rem;
        quo = '0;
        rem = '0;
        for (int b = 63; b >= 0; b--)
        begin
            rem = {rem[63:0], num[b]};
            if (rem >= {1'b0, den})
            begin
                rem    = rem - {1'b0, den};
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // sigmoid at cell midpoints over [-8, 8), Q.12, built at elaboration
    function automatic sig_table_t build_sig_table();
        sig_table_t  t;
        logic [63:0] e;
        logic [63:0] den;
        logic [63:0] q;
        int          i;
        e = 64'd1 << 32;
        for (int m = 1; m <= 255; m++)
        begin
            e = (e * EXP_STEP) >> 32;
            if (m[0])
            begin
                den = (64'd1 << 32) + e;
                q   = udiv64((64'd1 << 44) + (den >> 1), den);
                i   = 128 + ((m - 1) >> 1);
                t[i]       = ACT_W'(q);
                t[255 - i] = ACT_W'(64'd4096 - q);
            end
        end
        return t;
    endfunction

    localparam sig_table_t SIG_TABLE = build_sig_table();

endpackage

### hw/rtl/dls_ram.sv
// generic single-write, registered-read ram
`timescale 1ns / 1ps

module dls_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### hw/rtl/dls_front.sv
// front end: accepts items, classifies them and queues commands
`timescale 1ns / 1ps

module dls_front import dls_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,
    input  logic [1:0]  s_tuser,
    output logic        cmd_valid,
    input  logic        cmd_ready,
    output cmd_t        cmd
);

    cmd_t             q_mem_reg [CQ_DEPTH];
    logic [CQ_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [CQ_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CQ_AW:0]   count_reg, count_next;

    cmd_t in_cmd;
    logic row_ok, col_ok, keep, push, pop;

    always_comb
    begin
        in_cmd.kind  = mode_t'(s_tuser);
        in_cmd.row   = s_tdata[3:0];
        in_cmd.col   = s_tdata[7:4];
        in_cmd.value = s_tdata[23:8];
    end

    // loads aimed beyond a store are dropped here
    assign row_ok = (32'(in_cmd.row) < IN_MAX);
    assign col_ok = (32'(in_cmd.col) < OUT_MAX);

    always_comb
    begin
        unique case (in_cmd.kind)
            MODE_WEIGHT: keep = row_ok && col_ok;
            MODE_BIAS:   keep = col_ok;
            MODE_INPUT:  keep = row_ok;
            MODE_RUN:    keep = 1'b1;
            default:     keep = 1'b0;
        endcase
    end

    assign s_tready  = (count_reg != (CQ_AW + 1)'(CQ_DEPTH));
    assign push      = s_tvalid && s_tready && keep;
    assign cmd_valid = (count_reg != '0);
    assign pop       = cmd_valid && cmd_ready;
    assign cmd       = q_mem_reg[rd_ptr_reg];

    assign wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
    assign rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
    assign count_next  = count_reg + (CQ_AW + 1)'(push) - (CQ_AW + 1)'(pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem_reg[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

### hw/rtl/dls_back.sv
// back end: stores, multiply-accumulate pipeline, sigmoid and result queue
`timescale 1ns / 1ps

module dls_back import dls_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [SIZE_W-1:0] in_size,
    input  logic [SIZE_W-1:0] out_size,
    input  logic              cmd_valid,
    output logic              cmd_ready,
    input  cmd_t              cmd,
    output logic              res_valid,
    input  logic              res_ready,
    output res_t              res
);

    bk_state_t state_reg, state_next;

    logic [IN_AW-1:0]  j_reg, j_next;
    logic [OUT_AW-1:0] n_reg, n_next;
    logic [IN_AW-1:0]  ni_last_reg, ni_last_next;
    logic [OUT_AW-1:0] no_last_reg, no_last_next;
    logic [OQ_CW-1:0]  resv_reg, resv_next;

    logic signed [VAL_W-1:0] bias_mem_reg  [OUT_MAX];
    logic signed [VAL_W-1:0] input_mem_reg [IN_MAX];

    logic do_load, start_run, issue, issue_first, j_end, n_end;
    logic [WA_W-1:0]  w_waddr, w_raddr;
    logic [VAL_W-1:0] w_rdata;

    // pipeline stage 1: weight read in flight
    logic                    s1_valid_reg, s1_first_reg, s1_lastj_reg, s1_lastn_reg;
    logic [OUT_AW-1:0]       s1_n_reg;
    logic signed [VAL_W-1:0] s1_in_reg, s1_bias_reg;
    // stage 2: product
    logic                     s2_valid_reg, s2_first_reg, s2_lastj_reg, s2_lastn_reg;
    logic [OUT_AW-1:0]        s2_n_reg;
    logic signed [VAL_W-1:0]  s2_bias_reg;
    logic signed [PROD_W-1:0] s2_prod_reg, s2_prod_next;
    // stage 3: accumulator
    logic                    s3_done_reg, s3_lastn_reg;
    logic [OUT_AW-1:0]       s3_n_reg;
    logic signed [ACC_W-1:0] acc_reg, acc_next, acc_base;

    // activation and result queue
    logic       over, under, push, pop;
    logic [7:0] tbl_idx;
    res_t       new_res;
    res_t       oq_mem_reg [OQ_DEPTH];
    logic [OQ_AW-1:0] oq_wr_reg, oq_rd_reg;
    logic [OQ_CW-1:0] oq_cnt_reg;

    dls_ram #(
        .WIDTH (VAL_W),
        .DEPTH (IN_MAX * OUT_MAX)
    ) u_weight_ram (
        .clk   (clk),
        .we    (do_load && (cmd.kind == MODE_WEIGHT)),
        .waddr (w_waddr),
        .wdata (cmd.value),
        .raddr (w_raddr),
        .rdata (w_rdata)
    );

    assign w_waddr = WA_W'(32'(cmd.row) * OUT_MAX + 32'(cmd.col));
    assign w_raddr = WA_W'(32'(j_reg) * OUT_MAX + 32'(n_reg));

    assign j_end = (j_reg == ni_last_reg);
    assign n_end = (n_reg == no_last_reg);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (cmd_valid && (cmd.kind == MODE_RUN))
                begin
                    state_next = BK_RUN;
                end
            end
            BK_RUN:
            begin
                if (issue && j_end && n_end)
                begin
                    state_next = BK_IDLE;
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    // control outputs; a neuron starts only with a result slot reserved
    always_comb
    begin
        cmd_ready   = 1'b0;
        do_load     = 1'b0;
        start_run   = 1'b0;
        issue       = 1'b0;
        unique case (state_reg)
            BK_IDLE:
            begin
                cmd_ready = cmd_valid;
                do_load   = cmd_valid && (cmd.kind != MODE_RUN);
                start_run = cmd_valid && (cmd.kind == MODE_RUN);
            end
            BK_RUN:
            begin
                issue = (j_reg != '0) || (resv_reg < OQ_CW'(OQ_DEPTH));
            end
            default: ;
        endcase
        issue_first = issue && (j_reg == '0);
    end

    // sizes: zero acts as one, large values clip to the store
    always_comb
    begin
        ni_last_next = ni_last_reg;
        no_last_next = no_last_reg;
        if (start_run)
        begin
            priority if (in_size == '0)
                ni_last_next = '0;
            else if (32'(in_size) > IN_LIM)
                ni_last_next = IN_AW'(IN_LIM - 1);
            else
                ni_last_next = IN_AW'(in_size - 1'b1);
            priority if (out_size == '0)
                no_last_next = '0;
            else if (32'(out_size) > OUT_LIM)
                no_last_next = OUT_AW'(OUT_LIM - 1);
            else
                no_last_next = OUT_AW'(out_size - 1'b1);
        end
    end

    always_comb
    begin
        j_next = j_reg;
        n_next = n_reg;
        if (start_run)
        begin
            j_next = '0;
            n_next = '0;
        end
        else if (issue)
        begin
            if (j_end)
            begin
                j_next = '0;
                n_next = n_end ? '0 : n_reg + 1'b1;
            end
            else
            begin
                j_next = j_reg + 1'b1;
            end
        end
    end

    assign resv_next = resv_reg + OQ_CW'(issue_first) - OQ_CW'(pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= BK_IDLE;
            j_reg        <= '0;
            n_reg        <= '0;
            ni_last_reg  <= '0;
            no_last_reg  <= '0;
            resv_reg     <= '0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_done_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            j_reg        <= j_next;
            n_reg        <= n_next;
            ni_last_reg  <= ni_last_next;
            no_last_reg  <= no_last_next;
            resv_reg     <= resv_next;
            s1_valid_reg <= issue;
            s2_valid_reg <= s1_valid_reg;
            s3_done_reg  <= s2_valid_reg && s2_lastj_reg;
        end
    end

    // small stores
    always_ff @(posedge clk)
    begin
        if (do_load && (cmd.kind == MODE_BIAS))
        begin
            bias_mem_reg[OUT_AW'(cmd.col)] <= cmd.value;
        end
        if (do_load && (cmd.kind == MODE_INPUT))
        begin
            input_mem_reg[IN_AW'(cmd.row)] <= cmd.value;
        end
    end

    assign s2_prod_next = s1_in_reg * signed'(w_rdata);
    assign acc_base = s2_first_reg ? (ACC_W'(s2_bias_reg) <<< FRAC_SH) : acc_reg;
    assign acc_next = acc_base + ACC_W'(s2_prod_reg);

    // datapath stages; operands captured at issue so later loads cannot disturb them
    always_ff @(posedge clk)
    begin
        s1_first_reg <= (j_reg == '0);
        s1_lastj_reg <= j_end;
        s1_lastn_reg <= n_end;
        s1_n_reg     <= n_reg;
        s1_in_reg    <= input_mem_reg[j_reg];
        s1_bias_reg  <= bias_mem_reg[n_reg];

        s2_first_reg <= s1_first_reg;
        s2_lastj_reg <= s1_lastj_reg;
        s2_lastn_reg <= s1_lastn_reg;
        s2_n_reg     <= s1_n_reg;
        s2_bias_reg  <= s1_bias_reg;
        s2_prod_reg  <= s2_prod_next;

        if (s2_valid_reg)
        begin
            acc_reg      <= acc_next;
            s3_n_reg     <= s2_n_reg;
            s3_lastn_reg <= s2_lastn_reg;
        end
    end

    // saturate to [-8, 8) and index the table
    assign over  = !acc_reg[ACC_W-1] && (|acc_reg[ACC_W-2:SPAN_BIT]);
    assign under = acc_reg[ACC_W-1] && !(&acc_reg[ACC_W-2:SPAN_BIT]);

    always_comb
    begin
        priority if (over)
            tbl_idx = 8'hff;
        else if (under)
            tbl_idx = 8'h00;
        else
            tbl_idx = {~acc_reg[SPAN_BIT], acc_reg[SPAN_BIT-1:SPAN_BIT-7]};
        new_res.out_index  = IDX_W'(s3_n_reg);
        new_res.activation = SIG_TABLE[tbl_idx];
        new_res.last       = s3_lastn_reg;
    end

    // result queue, room guaranteed by the reservation count
    assign push      = s3_done_reg;
    assign res_valid = (oq_cnt_reg != '0);
    assign pop       = res_valid && res_ready;
    assign res       = oq_mem_reg[oq_rd_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oq_wr_reg  <= '0;
            oq_rd_reg  <= '0;
            oq_cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                oq_wr_reg <= oq_wr_reg + 1'b1;
            end
            if (pop)
            begin
                oq_rd_reg <= oq_rd_reg + 1'b1;
            end
            oq_cnt_reg <= oq_cnt_reg + OQ_CW'(push) - OQ_CW'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            oq_mem_reg[oq_wr_reg] <= new_res;
        end
    end

endmodule

### hw/rtl/dense_layer_sigmoid_unit.sv
// top level of the fully connected layer with sigmoid activation
`timescale 1ns / 1ps

// One fully connected layer with a logistic activation; loaded values are
// signed Q4.12, activations unsigned Q1.12. Items on the slave stream carry
// a mode in tuser: load weight (row, col), load bias (col), load input
// element (row), or run. Loads are taken one per cycle while the front
// queue has room and return nothing; a load whose index lies beyond a
// store is dropped. A run returns one item per output neuron, index 0
// first, with tlast on the final one: the sigmoid of bias plus the dot
// product of the inputs with that neuron's weight column, saturated to
// [-8, 8) and read from a 256-entry table of cell midpoints. A front queue
// of four commands accepts and classifies items while the back end works,
// so loads can queue behind a run. The back end has one 16x16
// multiply-accumulate unit fed by one weight memory read per cycle while
// a result slot is free for each new neuron. Only two results may be
// reserved at once and a slot frees when its result is taken, so a stalled
// result side holds the back end once both slots are taken. Sizes are
// clamped at run start: zero acts as one, values above the store size act
// as the store size. Stores hold no reset value; only loaded entries may be
// used. No clearing pass is needed after reset. The user must write
// configuration only while idle; the block itself does not enforce it.
module dense_layer_sigmoid_unit import dls_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    // slave stream
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [23:0]       s_tdata,   // row[3:0], col[7:4], value[23:8]
    input  logic [1:0]        s_tuser,   // mode[1:0]
    // master stream
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [23:0]       m_tdata,   // out_index[3:0], activation[16:4], zero fill
    output logic              m_tlast,
    // configuration writes
    input  logic              cfg_we,
    input  logic [CFG_AW-1:0] cfg_addr,
    input  logic [SIZE_W-1:0] cfg_wdata
);

    logic [SIZE_W-1:0] in_size_reg, in_size_next;
    logic [SIZE_W-1:0] out_size_reg, out_size_next;

    logic cmd_valid, cmd_ready;
    cmd_t cmd;
    res_t res;

    // register file
    always_comb
    begin
        in_size_next  = in_size_reg;
        out_size_next = out_size_reg;
        if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_IN_SIZE:  in_size_next  = cfg_wdata;
                REG_OUT_SIZE: out_size_next = cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_size_reg  <= SIZE_RESET;
            out_size_reg <= SIZE_RESET;
        end
        else
        begin
            in_size_reg  <= in_size_next;
            out_size_reg <= out_size_next;
        end
    end

    // accept and classify
    dls_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd)
    );

    // stores, mac pipeline and results
    dls_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_size   (in_size_reg),
        .out_size  (out_size_reg),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .res_valid (m_tvalid),
        .res_ready (m_tready),
        .res       (res)
    );

    assign m_tdata = {7'd0, res.activation, res.out_index};
    assign m_tlast = res.last;

endmodule

### hw/rtl/dls_checker.sv
// port-level checks for the dense sigmoid layer, bound to the top level
`timescale 1ns / 1ps

module dls_checker import dls_pkg::*; (
    input logic              clk,
    input logic              rst_n,
    input logic              m_tvalid,
    input logic              m_tready,
    input logic [23:0]       m_tdata,
    input logic              m_tlast,
    input logic              cfg_we,
    input logic [CFG_AW-1:0] cfg_addr,
    input logic [SIZE_W-1:0] cfg_wdata
);

    logic [SIZE_W-1:0] out_size_reg;
    logic [IDX_W-1:0]  exp_idx_reg;
    logic [IDX_W-1:0]  idx_last;
    logic              out_acc;

    assign out_acc = m_tvalid && m_tready;

    always_comb
    begin
        priority if (out_size_reg == '0)
            idx_last = '0;
        else if (32'(out_size_reg) > OUT_LIM)
            idx_last = IDX_W'(OUT_LIM - 1);
        else
            idx_last = IDX_W'(out_size_reg - 1'b1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_size_reg <= SIZE_RESET;
            exp_idx_reg  <= '0;
        end
        else
        begin
            if (cfg_we && (cfg_addr == REG_OUT_SIZE))
            begin
                out_size_reg <= cfg_wdata;
            end
            if (out_acc)
            begin
                exp_idx_reg <= m_tlast ? '0 : m_tdata[3:0] + 1'b1;
            end
        end
    end

    // a stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed while stalled");

    // neurons come out in order within a run
    a_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_acc |-> m_tdata[3:0] == exp_idx_reg)
        else $error("output index out of order");

    // tlast marks exactly the last neuron in use
    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_acc |-> m_tlast == (m_tdata[3:0] == idx_last))
        else $error("tlast does not match out_size");

    // no result right after reset
    a_reset: assert property (@(posedge clk)
        $rose(rst_n) |-> !m_tvalid)
        else $error("result valid out of reset");

endmodule

bind dense_layer_sigmoid_unit dls_checker u_dls_checker (.*);
